// ===== design/kblru_pkg.sv =====
// ----------------------------------------------------------------------------
// kblru_pkg
// Shared constants, types and codes for the k-bucket LRU table.
// ----------------------------------------------------------------------------
package kblru_pkg;

   localparam int K             = 20;
   localparam int ID_BITS       = 64;
   localparam int CNT_W         = $clog2(K + 1);
   localparam int NODE_ID_W     = 64;
   localparam int ENTRY_COUNT_W = 5;
   localparam int PREFIX_BITS_W = 64;
   localparam int PREFIX_LEN_W  = 7;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 4;

   // operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // register indexes (taken from paddr bit 3, 8-byte spacing)
   localparam logic REG_PREFIX_BITS = 1'b0;
   localparam logic REG_PREFIX_LEN  = 1'b1;

   typedef logic [ID_BITS-1:0] id_type;
   typedef logic [CNT_W-1:0]   cnt_type;

   typedef struct packed {
      logic look;       // compare cycle: register match
      logic shift_en;   // refresh: shift left from the match onward
      logic append_en;  // append at the tail slot
      logic occupied;   // slot index below fill count
      logic last;       // slot index is fill count - 1
      logic tail;       // slot index equals fill count
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

// ===== design/kblru_if.sv =====
// ----------------------------------------------------------------------------
// kblru_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface kblru_req_if;
   import kblru_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [NODE_ID_W-1:0] node_id;

   modport source (output valid, output op, output node_id, input ready);
   modport sink   (input valid, input op, input node_id, output ready);
endinterface

interface kblru_rsp_if;
   import kblru_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     present;
   logic                     covered;
   logic                     is_full;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, output accepted, output present, output covered,
                   output is_full, output entry_count, input ready);
   modport sink   (input valid, input accepted, input present, input covered,
                   input is_full, input entry_count, output ready);
endinterface

// ===== design/kbucket_lru_table_top.sv =====
// ----------------------------------------------------------------------------
// kbucket_lru_table_top
// Kademlia k-bucket: up to K identifiers in least-recently-seen order.
// ----------------------------------------------------------------------------
// Each request passes through a compare cycle in which every slot cell
// checks its stored identifier against the request and registers a match
// flag, then an update cycle in which the cells shift (refresh) or the tail
// cell loads (append) and the response register is written. A new request is
// accepted in the cycle after the update, so requests are taken one at a time;
// the update waits as long as a previous response is not yet taken. Slot 0
// holds the oldest entry. Slot contents have no reset; only slots below the
// fill count are ever compared, so no clearing pass runs after reset.
// Registers: prefix_bits at byte 0x0 (64 bits), prefix_len at 0x8 (7 bits);
// the user must make writes only while no request is open; not enforced here.
// ----------------------------------------------------------------------------
module kbucket_lru_table_top (
   input  logic                                clock,
   input  logic                                reset,
   kblru_req_if.sink                           req_ch,
   kblru_rsp_if.source                         rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kblru_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [kblru_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [kblru_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import kblru_pkg::*;

   // ---- configuration registers ----
   logic [PREFIX_BITS_W-1:0] prefix_bits_ff, prefix_bits_in;
   logic [PREFIX_LEN_W-1:0]  prefix_len_ff, prefix_len_in;
   logic                     csr_write;
   logic                     csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[3];

   always_comb begin
      prefix_bits_in = prefix_bits_ff;
      prefix_len_in  = prefix_len_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_PREFIX_BITS: prefix_bits_in = csr_pwdata[PREFIX_BITS_W-1:0];
            REG_PREFIX_LEN:  prefix_len_in  = csr_pwdata[PREFIX_LEN_W-1:0];
            default:         prefix_len_in  = prefix_len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_PREFIX_BITS: csr_prdata = CSR_DATA_W'(prefix_bits_ff);
         REG_PREFIX_LEN:  csr_prdata = CSR_DATA_W'(prefix_len_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---- control state ----
   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // request held for the compare and update cycles
   logic      cmd_op_ff;
   id_type    cmd_id_ff;
   logic      covered_ff, covered_in;

   // response payload
   logic                     rsp_accepted_ff, rsp_present_ff, rsp_covered_ff;
   logic                     rsp_full_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;

   logic     req_xfer, rsp_free, upd_fire, found, is_add, room, append, accepted;
   cnt_type  count_next;
   logic [K-1:0] match_vec;
   logic [K:0]   seen_vec;
   id_type       data_vec [K];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign upd_fire     = (state_ff == ST_UPDATE) && rsp_free;
   assign found        = |match_vec;
   assign is_add       = (cmd_op_ff == OP_ADD);
   assign room         = (count_ff < CNT_W'(K));
   assign append       = upd_fire && is_add && !found && room;
   assign accepted     = is_add && (found || room);
   assign count_next   = count_ff + CNT_W'(append);

   // prefix coverage of the held identifier, checked in the compare cycle
   always_comb begin
      covered_in = covered_ff;
      if (state_ff == ST_LOOK) begin
         covered_in = 1'b1;
         for (int i = 0; i < ID_BITS; i++) begin
            if ((PREFIX_LEN_W'(i) < prefix_len_ff) &&
                (prefix_bits_ff[i] != cmd_id_ff[ID_BITS-1-i])) begin
               covered_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_LOOK;
         ST_LOOK:   state_in = ST_UPDATE;
         ST_UPDATE: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;
      if (upd_fire) rsp_valid_in = 1'b1;
   end

   assign count_in = count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         prefix_bits_ff <= '0;
         prefix_len_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         prefix_bits_ff <= prefix_bits_in;
         prefix_len_ff  <= prefix_len_in;
      end
   end

   always_ff @(posedge clock) begin
      covered_ff <= covered_in;
      if (req_xfer) begin
         cmd_op_ff <= req_ch.op;
         cmd_id_ff <= req_ch.node_id[ID_BITS-1:0];
      end
      if (upd_fire) begin
         rsp_accepted_ff <= accepted;
         rsp_present_ff  <= found;
         rsp_covered_ff  <= covered_ff;
         rsp_full_ff     <= (count_next >= CNT_W'(K));
         rsp_count_ff    <= ENTRY_COUNT_W'(count_next);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.accepted    = rsp_accepted_ff;
   assign rsp_ch.present     = rsp_present_ff;
   assign rsp_ch.covered     = rsp_covered_ff;
   assign rsp_ch.is_full     = rsp_full_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   // ---- slot chain: slot i hands its identifier to slot i-1 on refresh ----
   assign seen_vec[0] = 1'b0;

   for (genvar i = 0; i < K; i++) begin : g_slot
      cell_ctrl_type ctrl;
      id_type        right;

      assign ctrl.look      = (state_ff == ST_LOOK);
      assign ctrl.shift_en  = upd_fire && is_add && found;
      assign ctrl.append_en = append;
      assign ctrl.occupied  = (CNT_W'(i) < count_ff);
      assign ctrl.last      = (CNT_W'(i + 1) == count_ff);
      assign ctrl.tail      = (CNT_W'(i) == count_ff);

      if (i < K - 1) begin : g_mid
         assign right = data_vec[i+1];
      end else begin : g_end
         assign right = cmd_id_ff;
      end

      kblru_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .id_in      (cmd_id_ff),
         .right_data (right),
         .seen_in    (seen_vec[i]),
         .data_out   (data_vec[i]),
         .match_out  (match_vec[i]),
         .seen_out   (seen_vec[i+1])
      );
   end

`ifndef SYNTHESIS
   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(K))
      else $error("fill count exceeds table size");

   // identifiers in the table are unique, so at most one slot matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(match_vec))
      else $error("more than one slot matched");

   // an append grows the table by exactly one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      append |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the table");

   // a lookup never changes the fill count
   a_lookup_stable: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && (cmd_op_ff == OP_LOOKUP)) |=> $stable(count_ff))
      else $error("lookup changed the fill count");
`endif

endmodule

// ===== design/kblru_cell.sv =====
// ----------------------------------------------------------------------------
// kblru_cell
// One table slot: holds an identifier, compares it, shifts from its neighbor.
// ----------------------------------------------------------------------------
module kblru_cell (
   input  logic                    clock,
   input  kblru_pkg::cell_ctrl_type ctrl,
   input  kblru_pkg::id_type       id_in,
   input  kblru_pkg::id_type       right_data,
   input  logic                    seen_in,
   output kblru_pkg::id_type       data_out,
   output logic                    match_out,
   output logic                    seen_out
);
   import kblru_pkg::*;

   id_type data_ff, data_in;
   logic   match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (ctrl.look) begin
         match_in = ctrl.occupied && (data_ff == id_in);
      end
      // refresh: this slot and all newer ones move one toward the old end
      if (ctrl.shift_en && ctrl.occupied && (seen_in || match_ff)) begin
         data_in = ctrl.last ? id_in : right_data;
      end else if (ctrl.append_en && ctrl.tail) begin
         data_in = id_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;
   assign seen_out  = seen_in || match_ff;

endmodule

// ===== test/tb_kbucket_lru_table_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kbucket_lru_table_top
// Self-checking regression for the k-bucket LRU table.
// ----------------------------------------------------------------------------
// A behavioral model of the bucket (identifier list in least-recently-seen
// order, fill count, prefix registers) predicts the response to every request
// transfer. A monitor compares each response transfer with the oldest
// prediction field by field. Stimulus covers the empty table, filling to K,
// rejection when full, refresh at both ends and in the middle, prefix
// matching over several register settings (the empty, full-width and
// too-long prefix lengths among them), random traffic and a long response
// stall that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_kbucket_lru_table_top;
   import kblru_pkg::*;

   typedef struct packed {
      logic                     accepted;
      logic                     present;
      logic                     covered;
      logic                     is_full;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } bucket_outcome_type;

   // Settle time before a register write.
   localparam int SETTLE_CYCLES = 8;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   kblru_req_if req_ch ();
   kblru_rsp_if rsp_ch ();

   kbucket_lru_table_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // Bucket model: slot 0 of bucket_ids is the oldest identifier.
   // ------------------------------------------------------------------------
   id_type                  bucket_ids[$];
   logic [PREFIX_BITS_W-1:0] model_prefix_bits;
   logic [PREFIX_LEN_W-1:0]  model_prefix_len;

   bucket_outcome_type pending_outcomes[$];
   int                 error_count;

   // Idle knobs for the sender and the receiver.
   bit sender_gaps_on;
   bit receiver_stalls_on;
   int rsp_hold_cycles;   // one-shot long stall, taken by the receiver

   // Prefix length as used for matching; too long is clamped to ID_BITS.
   function automatic int prefix_depth();
      return (model_prefix_len > ID_BITS) ? ID_BITS : int'(model_prefix_len);
   endfunction

   // Bucket position bit i faces identifier bit ID_BITS-1-i.
   function automatic bit prefix_covers(id_type id);
      for (int i = 0; i < prefix_depth(); i++)
         if (model_prefix_bits[i] != id[ID_BITS-1-i])
            return 1'b0;
      return 1'b1;
   endfunction

   // Identifier whose top bits carry the configured bucket position; the
   // remaining bits come from low_bits. With miss set, the deepest prefix bit
   // is flipped so the identifier just misses the bucket.
   function automatic id_type prefix_id(id_type low_bits, bit miss);
      id_type top_mask;
      id_type placed;
      int     depth;
      depth    = prefix_depth();
      top_mask = ~({ID_BITS{1'b1}} >> depth);
      for (int i = 0; i < ID_BITS; i++)
         placed[ID_BITS-1-i] = model_prefix_bits[i];
      placed = (placed & top_mask) | (low_bits & ~top_mask);
      if (miss && depth > 0)
         placed[ID_BITS-depth] = ~placed[ID_BITS-depth];
      return placed;
   endfunction

   // Apply one request to the model and return the response it should give.
   function automatic bucket_outcome_type bucket_apply(logic op, id_type id);
      bucket_outcome_type outcome;
      int                 slot;
      slot = -1;
      foreach (bucket_ids[i])
         if (slot < 0 && bucket_ids[i] == id)
            slot = i;
      outcome.accepted = 1'b0;
      outcome.present  = (slot >= 0);
      if (op == OP_ADD) begin
         if (slot >= 0) begin
            bucket_ids.delete(slot);
            bucket_ids = {bucket_ids, id};
            outcome.accepted = 1'b1;
         end else if (bucket_ids.size() < K) begin
            bucket_ids = {bucket_ids, id};
            outcome.accepted = 1'b1;
         end
      end
      outcome.covered     = prefix_covers(id);
      outcome.is_full     = (bucket_ids.size() >= K);
      outcome.entry_count = ENTRY_COUNT_W'(bucket_ids.size());
      return outcome;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, limit
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("kbucket_lru_table_top regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request sender: one transfer per call. valid stays high between
   // back-to-back items and only drops when a gap is drawn.
   // ------------------------------------------------------------------------
   task automatic send_request(logic op, id_type id);
      int                 gap;
      bucket_outcome_type outcome;
      gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.node_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      outcome          = bucket_apply(op, id);
      pending_outcomes = {pending_outcomes, outcome};
   endtask

   // Drop valid and wait until every response is in, plus some slack, so a
   // register write lands on an idle block.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write: setup, then access; pready is always high.
   task automatic csr_write(logic reg_idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == REG_PREFIX_BITS)
         model_prefix_bits = value;
      else
         model_prefix_len = value[PREFIX_LEN_W-1:0];
   endtask

   task automatic set_bucket_position(logic [PREFIX_BITS_W-1:0] bits,
                                      logic [CSR_DATA_W-1:0] len);
      drain_block();
      csr_write(REG_PREFIX_BITS, bits);
      csr_write(REG_PREFIX_LEN, len);
   endtask

   // ------------------------------------------------------------------------
   // Response receiver: random stall before each transfer, plus a one-shot
   // long hold-off counted here.
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = receiver_stalls_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------------
   function automatic void check_field(string field, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      bucket_outcome_type exp_out;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response transfer with none expected", $time);
            error_count++;
         end else begin
            exp_out = pending_outcomes.pop_front();
            check_field("accepted", int'(exp_out.accepted), int'(rsp_ch.accepted));
            check_field("present", int'(exp_out.present), int'(rsp_ch.present));
            check_field("covered", int'(exp_out.covered), int'(rsp_ch.covered));
            check_field("is_full", int'(exp_out.is_full), int'(rsp_ch.is_full));
            check_field("entry_count", int'(exp_out.entry_count),
                        int'(rsp_ch.entry_count));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Lookups into the empty table: nothing present, count stays zero.
   task automatic test_empty_lookups();
      send_request(OP_LOOKUP, '0);
      send_request(OP_LOOKUP, '1);
   endtask

   // Fill to K with the identifier extremes among the entries, refresh the
   // oldest entry of a partial table, reject when full, refresh oldest/newest.
   task automatic test_fill_and_refresh();
      id_type fill_ids[K];
      fill_ids[0] = '0;
      fill_ids[1] = '1;
      fill_ids[2] = {1'b1, {(ID_BITS-1){1'b0}}};
      fill_ids[3] = id_type'(1);
      for (int i = 4; i < K; i++)
         fill_ids[i] = {$urandom, $urandom};
      for (int i = 0; i < K; i++) begin
         send_request(OP_ADD, fill_ids[i]);
         if (i == 4)
            send_request(OP_ADD, fill_ids[0]);   // refresh inside a partial table
      end
      send_request(OP_ADD, {$urandom, $urandom});  // full: rejected
      send_request(OP_ADD, fill_ids[1]);           // now the oldest: refresh
      send_request(OP_ADD, fill_ids[1]);           // already newest
      send_request(OP_LOOKUP, fill_ids[10]);
      send_request(OP_LOOKUP, {$urandom, $urandom});
   endtask

   // Prefix matching across register settings; lookups leave the table alone.
   task automatic test_prefix_settings();
      logic [PREFIX_BITS_W-1:0] bits_set[6];
      logic [CSR_DATA_W-1:0]    len_set[6];
      bits_set[0] = '0;                     len_set[0] = '0;
      bits_set[1] = '1;                     len_set[1] = CSR_DATA_W'(ID_BITS);
      bits_set[2] = '0;                     len_set[2] = CSR_DATA_W'(ID_BITS);
      bits_set[3] = {$urandom, $urandom};   len_set[3] = CSR_DATA_W'(1);
      bits_set[4] = {$urandom, $urandom};   len_set[4] = CSR_DATA_W'(100);  // > id
      bits_set[5] = {$urandom, $urandom};   len_set[5] = CSR_DATA_W'(127);
      foreach (bits_set[i]) begin
         set_bucket_position(bits_set[i], len_set[i]);
         send_request(OP_LOOKUP, prefix_id({$urandom, $urandom}, 1'b0));
         send_request(OP_LOOKUP, prefix_id({$urandom, $urandom}, 1'b1));
         send_request(OP_LOOKUP, '0);
         send_request(OP_LOOKUP, '1);
      end
      // upper register bits beyond the 7-bit length field are dropped
      set_bucket_position(bits_set[3], {{(CSR_DATA_W-7){1'b1}}, 7'd5});
      send_request(OP_LOOKUP, prefix_id({$urandom, $urandom}, 1'b0));
   endtask

   // Random traffic: mostly identifiers already in the table (refreshes and
   // hits) or ones inside the bucket, the rest near misses and noise.
   task automatic random_burst(int count);
      id_type id;
      int     pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4 && bucket_ids.size() > 0)
            id = bucket_ids[$urandom_range(0, bucket_ids.size() - 1)];
         else if (pick < 7)
            id = prefix_id({$urandom, $urandom}, 1'b0);
         else if (pick == 7)
            id = prefix_id({$urandom, $urandom}, 1'b1);
         else
            id = {$urandom, $urandom};
         send_request(logic'($urandom_range(0, 1)), id);
      end
   endtask

   task automatic test_random_traffic();
      set_bucket_position({$urandom, $urandom}, CSR_DATA_W'(8));
      sender_gaps_on = 1; receiver_stalls_on = 1;
      random_burst(200);
      set_bucket_position('1, CSR_DATA_W'(ID_BITS));
      sender_gaps_on = 0; receiver_stalls_on = 0;
      random_burst(200);
      set_bucket_position({$urandom, $urandom}, CSR_DATA_W'($urandom_range(0, 127)));
      sender_gaps_on = 1; receiver_stalls_on = 0;
      random_burst(200);
      set_bucket_position('0, '0);
      sender_gaps_on = 0; receiver_stalls_on = 1;
      random_burst(200);
   endtask

   // Long response hold-off while requests keep coming back to back.
   task automatic test_backpressure();
      drain_block();
      sender_gaps_on  = 0;
      rsp_hold_cycles = 150;
      random_burst(16);
      sender_gaps_on     = 1;
      receiver_stalls_on = 1;
   endtask

   initial begin
      error_count        = 0;
      sender_gaps_on     = 1;
      receiver_stalls_on = 1;
      rsp_hold_cycles    = 0;
      model_prefix_bits  = '0;
      model_prefix_len   = '0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_ADD;
      req_ch.node_id <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_lookups();
      test_fill_and_refresh();
      test_prefix_settings();
      test_backpressure();
      test_random_traffic();
      test_backpressure();

      // wait out the last responses, then leave room for stray transfers
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("kbucket_lru_table_top regression: pass");
      else
         $display("kbucket_lru_table_top regression: fail");
      $finish;
   end

endmodule
